// File: src/bsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Types and constants for the bank switch mapper with IRQ counter.
// ----------------------------------------------------------------------------
package bsm_pkg;

    typedef struct packed {
        logic [15:0] cpu_address;
        logic        cpu_write;
        logic [7:0]  cpu_data;
        logic [13:0] ppu_address;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] prg_bank;
        logic       prg_ram_select;
        logic       prg_ram_writable;
        logic [7:0] chr_bank;
        logic       nametable_page;
        logic       irq_asserted;
    } out_beat_t;

    // CPU address pages (A15..A12) that decode writes
    localparam logic [3:0] PAGE_PRG_LO  = 4'h8;
    localparam logic [3:0] PAGE_PRG_HI  = 4'h9;
    localparam logic [3:0] PAGE_CHR_A   = 4'hA;
    localparam logic [3:0] PAGE_CHR_B   = 4'hB;
    localparam logic [3:0] PAGE_CHR_C   = 4'hC;
    localparam logic [3:0] PAGE_CHR_D   = 4'hD;
    localparam logic [3:0] PAGE_RELOAD  = 4'hE;
    localparam logic [3:0] PAGE_CTRL    = 4'hF;

    // $Fxxx register select (A1..A0)
    localparam logic [1:0] REG_IRQ_RELOAD = 2'd0;
    localparam logic [1:0] REG_IRQ_CTRL   = 2'd1;
    localparam logic [1:0] REG_MIRROR     = 2'd2;
    localparam logic [1:0] REG_SPEECH     = 2'd3;

    // nametable mirroring modes
    localparam logic [1:0] MIR_A11  = 2'd0;
    localparam logic [1:0] MIR_A10  = 2'd1;
    localparam logic [1:0] MIR_ZERO = 2'd2;
    localparam logic [1:0] MIR_ONE  = 2'd3;

    // CPU address window bounds
    localparam logic [15:0] ADDR_RAM_LO = 16'h6000;
    localparam logic [15:0] ADDR_ROM_LO = 16'h8000;
    localparam logic [15:0] ADDR_A000   = 16'hA000;
    localparam logic [15:0] ADDR_C000   = 16'hC000;
    localparam logic [15:0] ADDR_E000   = 16'hE000;

    localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;

    // IRQ counter width masks
    localparam logic [15:0] MASK_4  = 16'h000F;
    localparam logic [15:0] MASK_8  = 16'h00FF;
    localparam logic [15:0] MASK_12 = 16'h0FFF;
    localparam logic [15:0] MASK_16 = 16'hFFFF;

    // reset values of the program bank registers
    localparam logic [7:0] PRG0_RESET = 8'h00;
    localparam logic [7:0] PRG1_RESET = 8'h01;
    localparam logic [7:0] PRG2_RESET = 8'hFE;
    localparam logic [7:0] PRG3_RESET = 8'h00;

    function automatic logic [7:0] set_nibble(input logic [7:0] old_val,
                                              input logic       hi,
                                              input logic [3:0] nib);
        logic [7:0] res;
        res = hi ? {nib, old_val[3:0]} : {old_val[7:4], nib};
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/bank_switch_mapper_with_irq_counter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_counter_top
// Nibble-loaded bank registers, address translation and IRQ down counter.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake        | Payload
// s_      | in        | s_valid/s_ready  | bsm_pkg::in_beat_t  (one CPU bus cycle)
// m_      | out       | m_valid/m_ready  | bsm_pkg::out_beat_t (translated result)
//
// One beat per clock sustained while m_ready holds; an accepted beat goes through the input
// register, then register update and translation into the output register, which drives m_valid.
// Both stages advance together when the output register is empty or being taken.
// Reset (aresetn low, synchronous) restores the bank, counter and IRQ registers
// and empties both stages.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_irq_counter_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  bsm_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output bsm_pkg::out_beat_t  m_data
);
    import bsm_pkg::*;

    // pipeline registers
    logic       in_valid_reg;
    in_beat_t   in_reg;
    logic       out_valid_reg;
    out_beat_t  out_reg;

    // mapper state
    logic [3:0][7:0] prg_reg,    prg_next;
    logic [7:0][7:0] chr_reg,    chr_next;
    logic [3:0][3:0] reload_reg, reload_next;
    logic [15:0]     counter_reg, counter_next;
    logic [1:0]      mirror_reg, mirror_next;
    logic [3:0]      irq_ctl_reg, irq_ctl_next;
    logic            irq_line_reg, irq_line_next;

    logic            out_free;
    logic            advance;
    logic [3:0]      page;
    logic            release_wr;
    logic [15:0]     cnt_written;
    logic            line_written;
    logic [15:0]     cnt_mask;
    out_beat_t       result;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign page = in_reg.cpu_address[15:12];
    assign release_wr = in_reg.cpu_write && (page == PAGE_CTRL) &&
                        ((in_reg.cpu_address[1:0] == REG_IRQ_RELOAD) ||
                         (in_reg.cpu_address[1:0] == REG_IRQ_CTRL));

    // register write, then counter tick
    always_comb begin
        prg_next     = prg_reg;
        chr_next     = chr_reg;
        reload_next  = reload_reg;
        cnt_written  = counter_reg;
        mirror_next  = mirror_reg;
        irq_ctl_next = irq_ctl_reg;
        line_written = irq_line_reg;
        if (in_reg.cpu_write) begin
            unique case (page)
                PAGE_PRG_LO, PAGE_PRG_HI: begin
                    prg_next[{page[0], in_reg.cpu_address[1]}] =
                        set_nibble(prg_reg[{page[0], in_reg.cpu_address[1]}],
                                   in_reg.cpu_address[0], in_reg.cpu_data[3:0]);
                end
                PAGE_CHR_A, PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D: begin
                    // A..D map to rows 0..3
                    chr_next[{page[1:0] ^ 2'b10, in_reg.cpu_address[1]}] =
                        set_nibble(chr_reg[{page[1:0] ^ 2'b10, in_reg.cpu_address[1]}],
                                   in_reg.cpu_address[0], in_reg.cpu_data[3:0]);
                end
                PAGE_RELOAD: begin
                    reload_next[in_reg.cpu_address[1:0]] = in_reg.cpu_data[3:0];
                end
                PAGE_CTRL: begin
                    unique case (in_reg.cpu_address[1:0])
                        REG_IRQ_RELOAD: begin
                            cnt_written  = reload_reg;
                            line_written = 1'b0;
                        end
                        REG_IRQ_CTRL: begin
                            irq_ctl_next = in_reg.cpu_data[3:0];
                            line_written = 1'b0;
                        end
                        REG_MIRROR: begin
                            mirror_next = in_reg.cpu_data[1:0];
                        end
                        REG_SPEECH: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        priority if (irq_ctl_next[3]) begin
            cnt_mask = MASK_4;
        end else if (irq_ctl_next[2]) begin
            cnt_mask = MASK_8;
        end else if (irq_ctl_next[1]) begin
            cnt_mask = MASK_12;
        end else begin
            cnt_mask = MASK_16;
        end

        counter_next  = cnt_written;
        irq_line_next = line_written;
        if (irq_ctl_next[0]) begin
            counter_next = cnt_written - 16'd1;
            if ((cnt_written & cnt_mask) == 16'd0) begin
                irq_line_next = 1'b1;
            end
        end
    end

    // translation with the updated registers
    always_comb begin
        priority if (in_reg.cpu_address >= ADDR_E000) begin
            result.prg_bank = PRG_FIXED_BANK;
        end else if (in_reg.cpu_address >= ADDR_C000) begin
            result.prg_bank = prg_next[2];
        end else if (in_reg.cpu_address >= ADDR_A000) begin
            result.prg_bank = prg_next[1];
        end else if (in_reg.cpu_address >= ADDR_ROM_LO) begin
            result.prg_bank = prg_next[0];
        end else begin
            result.prg_bank = 8'd0;
        end
        result.prg_ram_select   = (in_reg.cpu_address >= ADDR_RAM_LO) &&
                                  (in_reg.cpu_address < ADDR_ROM_LO) && prg_next[3][0];
        result.prg_ram_writable = prg_next[3][0] && prg_next[3][1];
        result.chr_bank         = chr_next[in_reg.ppu_address[12:10]];
        unique case (mirror_next)
            MIR_A11:  result.nametable_page = in_reg.ppu_address[11];
            MIR_A10:  result.nametable_page = in_reg.ppu_address[10];
            MIR_ZERO: result.nametable_page = 1'b0;
            MIR_ONE:  result.nametable_page = 1'b1;
        endcase
        result.irq_asserted = irq_line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prg_reg       <= {PRG3_RESET, PRG2_RESET, PRG1_RESET, PRG0_RESET};
            chr_reg       <= '0;
            reload_reg    <= '0;
            counter_reg   <= '0;
            mirror_reg    <= MIR_A11;
            irq_ctl_reg   <= '0;
            irq_line_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                prg_reg      <= prg_next;
                chr_reg      <= chr_next;
                reload_reg   <= reload_next;
                counter_reg  <= counter_next;
                mirror_reg   <= mirror_next;
                irq_ctl_reg  <= irq_ctl_next;
                irq_line_reg <= irq_line_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    // IRQ line is sticky until a release write goes through
    a_irq_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (irq_line_reg && !(advance && release_wr)) |=> irq_line_reg)
        else $error("irq line dropped without a release write");

    // reload write with the counter stopped leaves the line released
    a_reload_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && release_wr && (in_reg.cpu_address[1:0] == REG_IRQ_RELOAD) &&
         !irq_ctl_reg[0]) |=> !m_data.irq_asserted)
        else $error("irq asserted after reload write with counter stopped");

    // the counter only moves when a beat goes through
    a_counter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(counter_reg))
        else $error("counter changed without a beat");

    // every processed beat lands in the output register
    a_beat_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed beat not presented");

endmodule
`default_nettype wire
